### design/assert_macros.svh
// Assertion macros shared by the bit crusher RTL.
// Included by files that carry concurrent checks; no other dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property must hold at every rising clock edge outside reset
`define ASSERT_AT(lbl, ck, rn, prop, msg) \
	lbl: assert property (@(posedge ck) disable iff (!(rn)) (prop)) else $error(msg);

// condition must never be seen at a rising clock edge outside reset
`define ASSERT_NEVER(lbl, ck, rn, cond, msg) \
	`ASSERT_AT(lbl, ck, rn, !(cond), msg)

`endif

### design/bca_pkg.sv
// Shared types, constants and elaboration-time functions of the bit crusher.
// No dependencies; used by every module of the block.
package bca_pkg;

	// default structural parameters
	localparam int SAMPLE_BITS_DEF     = 24;
	localparam int CHANNEL_COUNT_DEF   = 2;
	localparam int TANH_TABLE_BITS_DEF = 10;

	// register and counter widths
	localparam int DEPTH_W     = 5;
	localparam int FACTOR_W    = 13;
	localparam int MIX_W       = 17;
	localparam int CFG_DATA_W  = 17;
	localparam int CFG_INDEX_W = 2;
	localparam int CNT_SUM_W   = FACTOR_W + 1;
	localparam int FIFO_DEPTH  = 2;

	localparam logic [DEPTH_W-1:0]  BYPASS_DEPTH = 5'd24;
	localparam logic [DEPTH_W-1:0]  DEPTH_RESET  = 5'd16;
	localparam logic [FACTOR_W-1:0] FACTOR_ONE   = 13'd256;
	localparam logic [MIX_W-1:0]    MIX_ONE      = 17'd65536;

	typedef enum logic [CFG_INDEX_W-1:0] {
		CFG_BIT_DEPTH  = 2'd0,
		CFG_DOWNSAMPLE = 2'd1,
		CFG_MIX_GAIN   = 2'd2
	} cfg_index_t;

	// live configuration; factor and mix are stored already clamped
	typedef struct packed {
		logic [DEPTH_W-1:0]  bit_depth;
		logic [FACTOR_W-1:0] factor;
		logic [MIX_W-1:0]    mix;
	} cfg_t;

	// restoring unsigned division, elaboration only
	function automatic logic [63:0] udiv64(input logic [63:0] num, input logic [63:0] den);
		logic [64:0] rem;
		logic [63:0] quo;
		rem = '0;
		quo = '0;
		for (int i = 63; i >= 0; i--) begin
			rem = {rem[63:0], num[i]};
			if (rem >= {1'b0, den}) begin
				rem    = rem - {1'b0, den};
				quo[i] = 1'b1;
			end
		end
		return quo;
	endfunction

	// e^x for x in [0, 1], Q31 in and out, truncated Taylor terms
	function automatic logic [63:0] exp_q31(input logic [63:0] x);
		logic [63:0] term;
		logic [63:0] sum;
		term = 64'd1 << 31;
		sum  = term;
		for (int n = 1; n < 40; n++) begin
			if (term != 64'd0) begin
				term = udiv64((term * x) >> 31, 64'(n));
				sum  = sum + term;
			end
		end
		return sum;
	endfunction

	// tanh(k / 2^table_bits) in Q1.frac_bits, rounded half up
	function automatic logic [63:0] tanh_knot(input int k, input int table_bits,
			input int frac_bits);
		logic [63:0] x;
		logic [63:0] p;
		logic [63:0] m;
		logic [63:0] num;
		logic [63:0] den;
		logic [63:0] q;
		logic [63:0] r;
		x   = 64'(k) << (31 - table_bits);
		p   = exp_q31(x);
		m   = udiv64(64'd1 << 62, p);
		num = p - m;
		den = p + m;
		q   = '0;
		r   = num;
		for (int i = 0; i < frac_bits + 1; i++) begin
			r = r << 1;
			q = q << 1;
			if (r >= den) begin
				r = r - den;
				q = q | 64'd1;
			end
		end
		return (q + 64'd1) >> 1;
	endfunction

endpackage

### design/bca_front.sv
// Front end: accepts input words, runs tanh soft clip and the quantizer.
// Depends on bca_pkg; pushes {channel, quantized, dry} into the word queue.
module bca_front import bca_pkg::*; #(
	parameter int SAMPLE_BITS     = SAMPLE_BITS_DEF,
	parameter int CHANNEL_COUNT   = CHANNEL_COUNT_DEF,
	parameter int TANH_TABLE_BITS = TANH_TABLE_BITS_DEF,
	parameter int CH_W            = 1,
	parameter int QW              = CH_W + 2 * SAMPLE_BITS
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  cfg_t                          cfg,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic                          in_channel,
	input  logic signed [SAMPLE_BITS-1:0] in_sample,
	input  logic                          q_full,
	output logic                          q_push,
	output logic [QW-1:0]                 q_data
);

	localparam int FRAC  = SAMPLE_BITS - 1;
	localparam int SH    = FRAC - TANH_TABLE_BITS;
	localparam int KNOTS = (1 << TANH_TABLE_BITS) + 1;
	localparam int AW    = TANH_TABLE_BITS + 1;
	localparam int PW    = SAMPLE_BITS + SH;
	localparam int MW    = SAMPLE_BITS + 1;
	localparam int SW    = $clog2(SAMPLE_BITS);

	localparam logic [PW:0]          HALF_P = (PW + 1)'(1) << (SH - 1);
	localparam logic [DEPTH_W-1:0]   FRAC_D = DEPTH_W'(FRAC);
	localparam logic signed [MW-1:0] SMAX_M = {2'b00, {FRAC{1'b1}}};

	typedef enum logic [2:0] {F_IDLE, F_ROM, F_MUL, F_CLIP, F_OUT} fstate_t;

	fstate_t                       state_q;
	logic [CH_W-1:0]               ch_q;
	logic signed [SAMPLE_BITS-1:0] dry_q;
	logic [SAMPLE_BITS-1:0]        lo_q;
	logic [SAMPLE_BITS-1:0]        hi_q;
	logic [SH-1:0]                 frac_q;
	logic [PW-1:0]                 prod_q;
	logic [SAMPLE_BITS-1:0]        y_q;

	// tanh knots over [0, 1], built at elaboration
	logic [SAMPLE_BITS-1:0] tanh_rom [KNOTS];

	for (genvar k = 0; k < KNOTS; k++) begin : g_rom
		localparam logic [63:0] KV = tanh_knot(k, TANH_TABLE_BITS, FRAC);
		assign tanh_rom[k] = KV[SAMPLE_BITS-1:0];
	end

	// magnitude split into knot index and fraction
	logic [SAMPLE_BITS-1:0] mag_w;
	logic [AW-1:0]          idx_w;
	logic [AW-1:0]          idx_hi_w;
	logic [SAMPLE_BITS-1:0] diff_w;
	logic [PW:0]            psum_w;

	assign mag_w    = dry_q[SAMPLE_BITS-1] ? SAMPLE_BITS'(-dry_q) : SAMPLE_BITS'(dry_q);
	assign idx_w    = mag_w[SAMPLE_BITS-1:SH];
	// full-scale negative input lands on the last knot with zero fraction
	assign idx_hi_w = idx_w[AW-1] ? idx_w : idx_w + AW'(1);
	assign diff_w   = hi_q - lo_q;
	assign psum_w   = (PW + 1)'(prod_q) + HALF_P;

	// quantizer: round magnitude half away from zero, sign, saturate +1.0; bypass depth passes dry
	logic [DEPTH_W-1:0]          fb_w;
	logic [SW-1:0]               shamt_w;
	logic [MW-1:0]               one_sh_w;
	logic [MW-1:0]               rnd_w;
	logic signed [MW-1:0]        qv_w;
	logic signed [SAMPLE_BITS-1:0] q_w;

	always_comb begin
		fb_w = (cfg.bit_depth <= DEPTH_W'(1)) ? '0 : cfg.bit_depth - DEPTH_W'(1);
		if (fb_w > FRAC_D) begin
			fb_w = FRAC_D;
		end
		shamt_w  = SW'(FRAC_D - fb_w);
		one_sh_w = MW'(1) << shamt_w;
		rnd_w    = (MW'(y_q) + (one_sh_w >> 1)) & ~(one_sh_w - MW'(1));
		qv_w     = dry_q[SAMPLE_BITS-1] ? -$signed(rnd_w) : $signed(rnd_w);
		if (qv_w > SMAX_M) begin
			qv_w = SMAX_M;
		end
		if (cfg.bit_depth >= BYPASS_DEPTH) begin
			q_w = dry_q;
		end else begin
			q_w = qv_w[SAMPLE_BITS-1:0];
		end
	end

	assign in_ready = (state_q == F_IDLE);
	assign q_push   = (state_q == F_OUT) && !q_full;
	assign q_data   = {ch_q, q_w, dry_q};

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= F_IDLE;
		end else begin
			unique case (state_q)
				F_IDLE: if (in_valid) state_q <= F_ROM;
				F_ROM:  state_q <= F_MUL;
				F_MUL:  state_q <= F_CLIP;
				F_CLIP: state_q <= F_OUT;
				F_OUT:  if (!q_full) state_q <= F_IDLE;
				default: state_q <= F_IDLE;
			endcase
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		if (state_q == F_IDLE && in_valid) begin
			ch_q  <= (32'(in_channel) >= CHANNEL_COUNT) ? CH_W'(CHANNEL_COUNT - 1)
				: CH_W'(in_channel);
			dry_q <= in_sample;
		end
		if (state_q == F_ROM) begin
			lo_q   <= tanh_rom[idx_w];
			hi_q   <= tanh_rom[idx_hi_w];
			frac_q <= mag_w[SH-1:0];
		end
		if (state_q == F_MUL) begin
			prod_q <= PW'(diff_w) * PW'(frac_q);
		end
		if (state_q == F_CLIP) begin
			y_q <= lo_q + SAMPLE_BITS'(psum_w >> SH);
		end
	end

endmodule

### design/bca_fifo.sv
// Short word queue between the front and back ends.
// Depends on bca_pkg for its depth.
module bca_fifo import bca_pkg::*; #(
	parameter int WIDTH = 8
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  logic [WIDTH-1:0] push_data,
	output logic             full,
	input  logic             pop,
	output logic [WIDTH-1:0] pop_data,
	output logic             valid
);

	localparam int PTR_W = (FIFO_DEPTH > 1) ? $clog2(FIFO_DEPTH) : 1;
	localparam int CNT_W = $clog2(FIFO_DEPTH + 1);

	logic [WIDTH-1:0] mem_q [FIFO_DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;
	logic             do_push;
	logic             do_pop;

	assign full     = (count_q == CNT_W'(FIFO_DEPTH));
	assign valid    = (count_q != '0);
	assign do_push  = push && !full;
	assign do_pop   = pop && valid;
	assign pop_data = mem_q[rd_ptr_q];

	// pointers and fill level
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(FIFO_DEPTH - 1)) ? '0 : wr_ptr_q + PTR_W'(1);
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(FIFO_DEPTH - 1)) ? '0 : rd_ptr_q + PTR_W'(1);
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + CNT_W'(1);
			end else if (do_pop && !do_push) begin
				count_q <= count_q - CNT_W'(1);
			end
		end
	end

	// storage
	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= push_data;
		end
	end

endmodule

### design/bca_back.sv
// Back end: per-channel hold counter, sample-and-hold and dry/wet mix.
// Depends on bca_pkg and assert_macros.svh; drives the master-side stream.
`include "assert_macros.svh"

module bca_back import bca_pkg::*; #(
	parameter int SAMPLE_BITS   = SAMPLE_BITS_DEF,
	parameter int CHANNEL_COUNT = CHANNEL_COUNT_DEF,
	parameter int CH_W          = 1,
	parameter int QW            = CH_W + 2 * SAMPLE_BITS,
	parameter int TDATA_W       = 24
) (
	input  logic               clk,
	input  logic               arst_n,
	input  cfg_t               cfg,
	input  logic               fifo_valid,
	output logic               fifo_pop,
	input  logic [QW-1:0]      fifo_data,
	output logic               m_tvalid,
	input  logic               m_tready,
	output logic [TDATA_W-1:0] m_tdata    // sample_out
);

	localparam int PM   = SAMPLE_BITS + 18;
	localparam int AC   = SAMPLE_BITS + 19;
	localparam int RW   = AC - 16;
	localparam int FRAC = SAMPLE_BITS - 1;
	localparam int BW   = $clog2(CNT_SUM_W);

	localparam logic signed [AC-1:0] RND_A  = AC'(32768);
	localparam logic signed [RW-1:0] SMAX_R = RW'((64'sd1 <<< FRAC) - 64'sd1);
	localparam logic signed [RW-1:0] SMIN_R = RW'(-(64'sd1 <<< FRAC));
	localparam logic [CNT_SUM_W-1:0] ONE_C  = {1'b0, FACTOR_ONE};

	typedef enum logic [2:0] {B_IDLE, B_SUM, B_CNT, B_MOD, B_MIX1, B_MIX2} bstate_t;

	bstate_t                       state_q;
	logic                          out_valid_q;
	logic [SAMPLE_BITS-1:0]        out_data_q;
	logic [FACTOR_W-1:0]           hold_cnt_q [CHANNEL_COUNT];
	logic signed [SAMPLE_BITS-1:0] held_q [CHANNEL_COUNT];

	logic [CH_W-1:0]               ch_q;
	logic signed [SAMPLE_BITS-1:0] dry_q;
	logic signed [SAMPLE_BITS-1:0] q_q;
	logic [FACTOR_W-1:0]           factor_q;
	logic [MIX_W-1:0]              mix_q;
	logic [CNT_SUM_W-1:0]          cnt_q;
	logic [FACTOR_W-1:0]           rem_q;
	logic [BW-1:0]                 bit_q;
	logic signed [PM-1:0]          pd_q;
	logic signed [PM-1:0]          pw_q;

	assign fifo_pop = (state_q == B_IDLE) && fifo_valid;
	assign m_tvalid = out_valid_q;
	assign m_tdata  = TDATA_W'(out_data_q);

	// one restoring remainder step per cycle
	logic [CNT_SUM_W-1:0] rem_sh_w;
	logic [FACTOR_W-1:0]  rem_nx_w;

	assign rem_sh_w = {rem_q, cnt_q[bit_q]};
	assign rem_nx_w = (rem_sh_w >= {1'b0, factor_q})
		? FACTOR_W'(rem_sh_w - {1'b0, factor_q}) : rem_sh_w[FACTOR_W-1:0];

	// wet pick and final rounding / saturation
	logic signed [SAMPLE_BITS-1:0] wet_w;
	logic signed [AC-1:0]          acc_w;
	logic signed [RW-1:0]          res_w;
	logic signed [RW-1:0]          sat_w;

	assign wet_w = (factor_q > FACTOR_ONE) ? held_q[ch_q] : q_q;
	assign acc_w = AC'(pd_q) + AC'(pw_q) + RND_A;
	assign res_w = $signed(acc_w[AC-1:16]);

	always_comb begin
		priority if (res_w > SMAX_R) begin
			sat_w = SMAX_R;
		end else if (res_w < SMIN_R) begin
			sat_w = SMIN_R;
		end else begin
			sat_w = res_w;
		end
	end

	// sequencer, channel state and output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= B_IDLE;
			out_valid_q <= 1'b0;
			for (int c = 0; c < CHANNEL_COUNT; c++) begin
				hold_cnt_q[c] <= '0;
				held_q[c]     <= '0;
			end
		end else begin
			unique case (state_q)
				B_IDLE: if (fifo_valid) state_q <= B_SUM;
				B_SUM:  state_q <= B_CNT;
				B_CNT: begin
					priority if (cnt_q < {1'b0, factor_q}) begin
						hold_cnt_q[ch_q] <= cnt_q[FACTOR_W-1:0];
						state_q          <= B_MIX1;
					end else if (cnt_q < {factor_q, 1'b0}) begin
						hold_cnt_q[ch_q] <= FACTOR_W'(cnt_q - {1'b0, factor_q});
						held_q[ch_q]     <= q_q;
						state_q          <= B_MIX1;
					end else begin
						state_q <= B_MOD;
					end
				end
				B_MOD: begin
					if (bit_q == '0) begin
						hold_cnt_q[ch_q] <= rem_nx_w;
						held_q[ch_q]     <= q_q;
						state_q          <= B_MIX1;
					end
				end
				B_MIX1: state_q <= B_MIX2;
				B_MIX2: begin
					if (!out_valid_q || m_tready) begin
						state_q <= B_IDLE;
					end
				end
				default: state_q <= B_IDLE;
			endcase
			// output valid: load a finished word or retire the one taken
			if (state_q == B_MIX2 && (!out_valid_q || m_tready)) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && m_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		if (state_q == B_IDLE && fifo_valid) begin
			ch_q     <= fifo_data[QW-1 -: CH_W];
			q_q      <= $signed(fifo_data[2*SAMPLE_BITS-1:SAMPLE_BITS]);
			dry_q    <= $signed(fifo_data[SAMPLE_BITS-1:0]);
			factor_q <= cfg.factor;
			mix_q    <= cfg.mix;
		end
		if (state_q == B_SUM) begin
			cnt_q <= {1'b0, hold_cnt_q[ch_q]} + ONE_C;
		end
		if (state_q == B_CNT) begin
			rem_q <= '0;
			bit_q <= BW'(CNT_SUM_W - 1);
		end
		if (state_q == B_MOD) begin
			rem_q <= rem_nx_w;
			bit_q <= bit_q - BW'(1);
		end
		if (state_q == B_MIX1) begin
			pd_q <= dry_q * $signed({1'b0, MIX_ONE - mix_q});
			pw_q <= wet_w * $signed({1'b0, mix_q});
		end
		if (state_q == B_MIX2 && (!out_valid_q || m_tready)) begin
			out_data_q <= sat_w[SAMPLE_BITS-1:0];
		end
	end

	// checks
	`ASSERT_AT(a_rem_below_factor, clk, arst_n, (state_q == B_MOD) |-> (rem_q < factor_q), "remainder reached the factor")
	`ASSERT_AT(a_counter_wrapped, clk, arst_n, (state_q == B_MIX1) |-> (hold_cnt_q[ch_q] < factor_q), "hold counter left at or above factor")
	`ASSERT_AT(a_stall_keeps_word, clk, arst_n, (state_q == B_MIX2 && out_valid_q && !m_tready) |=> (state_q == B_MIX2 && $stable(out_data_q)), "pending output word overwritten")
	`ASSERT_NEVER(a_pop_needs_word, clk, arst_n, fifo_pop && !fifo_valid, "pop from empty queue")

endmodule

### design/bit_crusher_audio.sv
// Bit crusher with tanh soft clip, quantizer, per-channel sample-and-hold and mix.
// Top level: configuration registers and the front / queue / back split.
// Depends on bca_pkg, bca_front, bca_fifo and bca_back.
//
// Each input word passes through the front end (accept, tanh ROM read,
// interpolation multiply, interpolation add, quantize and push) and then
// the back end (pop, counter add, counter compare, two mix steps); neither
// half takes a new word before it is through with the last one. When a
// lowered hold period leaves a counter that, after its add, is at least
// twice the new period, the counter wrap runs a one-bit-per-cycle remainder
// in the back end. A two-word queue between the halves lets the front keep
// accepting while a finished word waits on m_tready. The tanh table is a
// constant ROM of 2^TANH_TABLE_BITS+1 knots built at elaboration; no clearing
// pass follows reset. The back end takes its configuration as each word is
// popped; the front end reads the bit depth live while it quantizes.
module bit_crusher_audio import bca_pkg::*; #(
	parameter int SAMPLE_BITS     = SAMPLE_BITS_DEF,
	parameter int CHANNEL_COUNT   = CHANNEL_COUNT_DEF,
	parameter int TANH_TABLE_BITS = TANH_TABLE_BITS_DEF,
	localparam int TDATA_W        = ((SAMPLE_BITS + 7) / 8) * 8
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   s_tvalid,
	output logic                   s_tready,
	input  logic [TDATA_W-1:0]     s_tdata,    // sample_in
	input  logic [0:0]             s_tuser,    // channel
	output logic                   m_tvalid,
	input  logic                   m_tready,
	output logic [TDATA_W-1:0]     m_tdata,    // sample_out
	input  logic                   cfg_we,
	input  logic [CFG_INDEX_W-1:0] cfg_index,
	input  logic [CFG_DATA_W-1:0]  cfg_data
);

	localparam int CH_W = (CHANNEL_COUNT > 1) ? $clog2(CHANNEL_COUNT) : 1;
	localparam int QW   = CH_W + 2 * SAMPLE_BITS;

	cfg_t cfg_q;

	// configuration registers; period and mix are clamped on write
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.bit_depth <= DEPTH_RESET;
			cfg_q.factor    <= FACTOR_ONE;
			cfg_q.mix       <= MIX_ONE;
		end else if (cfg_we) begin
			unique case (cfg_index_t'(cfg_index))
				CFG_BIT_DEPTH:  cfg_q.bit_depth <= cfg_data[DEPTH_W-1:0];
				CFG_DOWNSAMPLE: cfg_q.factor <= (cfg_data[FACTOR_W-1:0] < FACTOR_ONE)
					? FACTOR_ONE : cfg_data[FACTOR_W-1:0];
				CFG_MIX_GAIN:   cfg_q.mix <= (cfg_data > MIX_ONE) ? MIX_ONE : cfg_data;
				default: ;
			endcase
		end
	end

	logic          q_push;
	logic          q_full;
	logic [QW-1:0] q_wdata;
	logic          q_pop;
	logic          q_valid;
	logic [QW-1:0] q_rdata;

	// soft clip and quantizer
	bca_front #(
		.SAMPLE_BITS     (SAMPLE_BITS),
		.CHANNEL_COUNT   (CHANNEL_COUNT),
		.TANH_TABLE_BITS (TANH_TABLE_BITS),
		.CH_W            (CH_W),
		.QW              (QW)
	) u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg        (cfg_q),
		.in_valid   (s_tvalid),
		.in_ready   (s_tready),
		.in_channel (s_tuser[0]),
		.in_sample  ($signed(s_tdata[SAMPLE_BITS-1:0])),
		.q_full     (q_full),
		.q_push     (q_push),
		.q_data     (q_wdata)
	);

	// word queue
	bca_fifo #(
		.WIDTH (QW)
	) u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (q_push),
		.push_data (q_wdata),
		.full      (q_full),
		.pop       (q_pop),
		.pop_data  (q_rdata),
		.valid     (q_valid)
	);

	// hold and mix
	bca_back #(
		.SAMPLE_BITS   (SAMPLE_BITS),
		.CHANNEL_COUNT (CHANNEL_COUNT),
		.CH_W          (CH_W),
		.QW            (QW),
		.TDATA_W       (TDATA_W)
	) u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg        (cfg_q),
		.fifo_valid (q_valid),
		.fifo_pop   (q_pop),
		.fifo_data  (q_rdata),
		.m_tvalid   (m_tvalid),
		.m_tready   (m_tready),
		.m_tdata    (m_tdata)
	);

endmodule
